### design/url_domain_hash_partitioner_core_macros.svh
// Assertion macros for the partitioner RTL, included by udhp_back.
// Each macro expects i_clk and i_rst_n in the scope where it is used.
`ifndef URL_DOMAIN_HASH_PARTITIONER_CORE_MACROS_SVH
`define URL_DOMAIN_HASH_PARTITIONER_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define UDHP_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define UDHP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define UDHP_ASSERT_IMPL(lbl, ante, cons, msg)
`define UDHP_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

### design/udhp_pkg.sv
// Types, constants and codes of the URL domain hash partitioner.
// No dependencies; the other design modules and interfaces use it.
package udhp_pkg;

    localparam int MAX_URL_BYTES = 4096;
    localparam int BYTES_W       = $clog2(MAX_URL_BYTES + 2);
    localparam int BYTE_W        = 8;
    localparam int HASH_W        = 20;
    localparam int BUCKET_W      = 16;
    localparam int REASON_W      = 2;
    localparam int DIV_STEPS     = HASH_W;
    localparam int CNT_W         = $clog2(DIV_STEPS);
    localparam int QUEUE_DEPTH   = 2;
    localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

    localparam logic [HASH_W-1:0] HASH_MAX = {HASH_W{1'b1}};

    localparam logic [BYTE_W-1:0] CH_DOT   = 8'h2E;
    localparam logic [BYTE_W-1:0] CH_SLASH = 8'h2F;
    localparam logic [BYTE_W-1:0] CH_HASH  = 8'h23;
    localparam logic [BYTE_W-1:0] CH_QUERY = 8'h3F;
    localparam logic [BYTE_W-1:0] CH_G     = 8'h67;
    localparam logic [3*BYTE_W-1:0] STR_BLO = 24'h626C6F;

    typedef enum logic [REASON_W-1:0] {
        RSN_NONE  = 2'd0,
        RSN_BLOG  = 2'd1,
        RSN_QUERY = 2'd2,
        RSN_LONG  = 2'd3
    } t_reason;

    typedef enum logic [1:0] {
        PH_PRE    = 2'd0,
        PH_DOMAIN = 2'd1,
        PH_PATH   = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        BK_IDLE = 2'd0,
        BK_DIV  = 2'd1,
        BK_DONE = 2'd2
    } t_back_state;

    // Per-URL verdict handed from the scanner to the bucket stage.
    typedef struct packed {
        t_reason             reason;
        logic [HASH_W-1:0]   hash;
    } t_summary;

endpackage

### design/udhp_in_if.sv
// Byte stream channel into the partitioner: valid/ready plus one URL byte.
// Depends on udhp_pkg for field widths.
interface udhp_in_if;
    logic                         valid;
    logic                         ready;
    logic [udhp_pkg::BYTE_W-1:0]  url_byte;
    logic                         last_byte;

    modport source (output valid, output url_byte, output last_byte, input ready);
    modport sink   (input valid, input url_byte, input last_byte, output ready);
endinterface

### design/udhp_out_if.sv
// Result channel out of the partitioner: valid/ready plus one verdict.
// Depends on udhp_pkg for field widths.
interface udhp_out_if;
    logic                           valid;
    logic                           ready;
    logic                           accepted;
    logic [udhp_pkg::REASON_W-1:0]  reject_reason;
    logic [udhp_pkg::HASH_W-1:0]    domain_hash;
    logic [udhp_pkg::BUCKET_W-1:0]  bucket;

    modport source (output valid, output accepted, output reject_reason,
                    output domain_hash, output bucket, input ready);
    modport sink   (input valid, input accepted, input reject_reason,
                    input domain_hash, input bucket, output ready);
endinterface

### design/url_domain_hash_partitioner_core.sv
// Top level of the URL domain hash partitioner: config register and wiring.
// Depends on udhp_pkg, udhp_in_if, udhp_out_if, udhp_front, udhp_queue, udhp_back.
//
//  channel   | dir | payload                                        | handshake
//  ----------+-----+------------------------------------------------+-----------
//  i_in      | in  | url_byte[7:0], last_byte                       | valid/ready
//  o_out     | out | accepted, reject_reason[1:0], domain_hash[19:0],| valid/ready
//            |     | bucket[15:0]                                   |
//  i_cfg_*   | in  | bucket_count[15:0]                             | write enable
//
// Bytes are taken one per cycle; the scanner stalls only while the summary
// queue (two entries) is full. Each URL then passes through the queue pop, the
// bit-serial divider and the output register; the back stage works on one URL
// at a time and pops the next summary only after loading the output register.
// The divider overlaps the next URL's bytes.
// Reset is synchronous: bucket_count returns to 1 and all control state clears;
// no clearing pass. A stalled output holds its register; the divider finishes
// its URL and waits, while the scanner keeps working until the queue fills.
module url_domain_hash_partitioner_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    udhp_in_if.sink                       i_in,
    udhp_out_if.source                    o_out,
    input  logic                          i_cfg_we,
    input  logic [udhp_pkg::BUCKET_W-1:0] i_cfg_wdata
);
    import udhp_pkg::*;

    // partition count; the user must write it only while the block is idle, which the block does not enforce
    logic [BUCKET_W-1:0] r_bucket_count;

    logic      q_push;
    logic      q_full;
    logic      q_pop;
    logic      q_valid;
    t_summary  q_in_data;
    t_summary  q_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bucket_count <= BUCKET_W'(1);
        end else if (i_cfg_we) begin
            r_bucket_count <= i_cfg_wdata;
        end
    end

    // front: classify bytes, hand one summary per URL to the queue
    udhp_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_q_full (q_full),
        .o_q_push (q_push),
        .o_q_data (q_in_data)
    );

    // decouple scanner from divider so each can stall on its own
    udhp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in_data),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_out_data)
    );

    // back: reduce the hash modulo the bucket count and present the transaction
    udhp_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_bucket_count (r_bucket_count),
        .i_q_valid      (q_valid),
        .i_q_data       (q_out_data),
        .o_q_pop        (q_pop),
        .o_out          (o_out)
    );
endmodule

### design/udhp_front.sv
// Byte scanner: tracks phase, domain hash and filters, emits a summary per URL.
// Depends on udhp_pkg and udhp_in_if.
module udhp_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    udhp_in_if.sink             i_in,
    input  logic                i_q_full,
    output logic                o_q_push,
    output udhp_pkg::t_summary  o_q_data
);
    import udhp_pkg::*;

    t_phase               r_phase, n_phase;
    logic [HASH_W-1:0]    r_hash, n_hash;
    logic [3*BYTE_W-1:0]  r_recent, n_recent;
    logic                 r_blog, n_blog;
    logic                 r_query, n_query;
    logic [BYTES_W-1:0]   r_bytes, n_bytes;

    logic                 take;
    logic [BYTE_W-1:0]    b;
    logic [BYTE_W-1:0]    mag;
    logic [HASH_W:0]      sum;
    logic                 too_long;

    assign i_in.ready = !i_q_full;
    assign take       = i_in.valid && i_in.ready;
    assign b          = i_in.url_byte;
    // two's complement magnitude; 0x80 maps to 128, which fits in 8 bits
    assign mag        = b[BYTE_W-1] ? (~b + BYTE_W'(1)) : b;
    assign sum        = {1'b0, r_hash} + (HASH_W+1)'(mag);

    always_comb begin
        n_bytes  = (r_bytes <= BYTES_W'(MAX_URL_BYTES)) ? r_bytes + BYTES_W'(1) : r_bytes;
        n_query  = r_query || (b == CH_HASH) || (b == CH_QUERY);
        n_blog   = r_blog || ((b == CH_G) && (r_recent == STR_BLO));
        n_recent = {r_recent[2*BYTE_W-1:0], b};
        n_phase  = r_phase;
        n_hash   = r_hash;
        unique case (r_phase)
            PH_PRE: begin
                if (b == CH_DOT) n_phase = PH_DOMAIN;
            end
            PH_DOMAIN: begin
                if (b == CH_SLASH) begin
                    n_phase = PH_PATH;
                end else begin
                    n_hash = sum[HASH_W] ? HASH_MAX : sum[HASH_W-1:0];
                end
            end
            PH_PATH: begin
            end
            default: begin
            end
        endcase
    end

    assign too_long = n_bytes > BYTES_W'(MAX_URL_BYTES);

    always_comb begin
        o_q_data.hash = n_hash;
        priority if (too_long) o_q_data.reason = RSN_LONG;
        else if (n_blog)       o_q_data.reason = RSN_BLOG;
        else if (n_query)      o_q_data.reason = RSN_QUERY;
        else                   o_q_data.reason = RSN_NONE;
    end

    assign o_q_push = take && i_in.last_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || o_q_push) begin
            // drop per-URL state after the last byte
            r_phase  <= PH_PRE;
            r_hash   <= '0;
            r_recent <= '0;
            r_blog   <= 1'b0;
            r_query  <= 1'b0;
            r_bytes  <= '0;
        end else if (take) begin
            r_phase  <= n_phase;
            r_hash   <= n_hash;
            r_recent <= n_recent;
            r_blog   <= n_blog;
            r_query  <= n_query;
            r_bytes  <= n_bytes;
        end
    end
endmodule

### design/udhp_queue.sv
// Short FIFO of URL summaries between the scanner and the bucket stage.
// Depends on udhp_pkg.
module udhp_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  udhp_pkg::t_summary  i_data,
    output logic                o_full,
    input  logic                i_pop,
    output logic                o_valid,
    output udhp_pkg::t_summary  o_data
);
    import udhp_pkg::*;

    t_summary            r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_wr_ptr;
    logic [QPTR_W-1:0]   r_rd_ptr;
    logic [QCNT_W-1:0]   r_count;
    logic                do_push;
    logic                do_pop;

    assign o_full  = r_count == QCNT_W'(QUEUE_DEPTH);
    assign o_valid = r_count != '0;
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wr_ptr] <= i_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + QPTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + QPTR_W'(1);
            end
            unique case ({do_push, do_pop})
                2'b10:   r_count <= r_count + QCNT_W'(1);
                2'b01:   r_count <= r_count - QCNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end
endmodule

### design/udhp_back.sv
// Bucket stage: restoring divider, one quotient bit per cycle, and output register.
// Depends on udhp_pkg, udhp_out_if and the assertion macro header.
`include "url_domain_hash_partitioner_core_macros.svh"
module udhp_back (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [udhp_pkg::BUCKET_W-1:0] i_bucket_count,
    input  logic                      i_q_valid,
    input  udhp_pkg::t_summary        i_q_data,
    output logic                      o_q_pop,
    udhp_out_if.source                o_out
);
    import udhp_pkg::*;

    t_back_state          r_state, n_state;
    logic [CNT_W-1:0]     r_cnt;
    logic [HASH_W-1:0]    r_dvd;
    logic [BUCKET_W-1:0]  r_rem;
    t_summary             r_sum;

    logic                 r_out_valid;
    logic                 r_out_acc;
    t_reason              r_out_reason;
    logic [HASH_W-1:0]    r_out_hash;
    logic [BUCKET_W-1:0]  r_out_bucket;

    logic [BUCKET_W-1:0]  divisor;
    logic [BUCKET_W:0]    rem_sh;
    logic                 rem_ge;
    logic                 load_out;
    logic                 last_step;

    assign divisor   = (i_bucket_count == '0) ? BUCKET_W'(1) : i_bucket_count;
    assign rem_sh    = {r_rem, r_dvd[HASH_W-1]};
    assign rem_ge    = rem_sh >= {1'b0, divisor};
    assign last_step = r_cnt == CNT_W'(DIV_STEPS - 1);

    always_comb begin
        n_state  = r_state;
        o_q_pop  = 1'b0;
        load_out = 1'b0;
        unique case (r_state)
            BK_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    n_state = BK_DIV;
                end
            end
            BK_DIV: begin
                if (last_step) n_state = BK_DONE;
            end
            BK_DONE: begin
                if (!r_out_valid || o_out.ready) begin
                    load_out = 1'b1;
                    n_state  = BK_IDLE;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= BK_IDLE;
        else          r_state <= n_state;
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_sum <= i_q_data;
            r_dvd <= i_q_data.hash;
            r_rem <= '0;
            r_cnt <= '0;
        end else if (r_state == BK_DIV) begin
            r_dvd <= {r_dvd[HASH_W-2:0], 1'b0};
            r_rem <= rem_ge ? BUCKET_W'(rem_sh - {1'b0, divisor}) : rem_sh[BUCKET_W-1:0];
            r_cnt <= r_cnt + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_acc    <= r_sum.reason == RSN_NONE;
            r_out_reason <= r_sum.reason;
            r_out_hash   <= r_sum.hash;
            r_out_bucket <= (r_sum.reason == RSN_NONE) ? r_rem : '0;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.accepted      = r_out_acc;
    assign o_out.reject_reason = r_out_reason;
    assign o_out.domain_hash   = r_out_hash;
    assign o_out.bucket        = r_out_bucket;

    `UDHP_ASSERT_IMPL(a_rem_below_div, r_state == BK_DIV, r_rem < divisor, "remainder not reduced")
    `UDHP_ASSERT_NEXT(a_div_ends, (r_state == BK_DIV) && last_step, r_state == BK_DONE, "divider overran")
    `UDHP_ASSERT_IMPL(a_reject_no_bucket, o_out.valid && !o_out.accepted, o_out.bucket == '0, "rejected URL has bucket")
endmodule

### tb/tb_url_domain_hash_partitioner_core.sv
// Self-checking testbench of url_domain_hash_partitioner_core: URL bytes in, verdicts out.
// Depends on udhp_pkg, udhp_in_if, udhp_out_if and the core with its submodules.
// A directed table comes first, then random URLs under several bucket counts.
module tb_url_domain_hash_partitioner_core;
    timeunit 1ns;
    timeprecision 1ps;

    import udhp_pkg::*;

    // Cycles to let pass after the last verdict before touching the register.
    localparam int SETTLE_CYCLES = 40;
    // Bytes of random URLs sent per bucket count setting.
    localparam int PHASE_BYTES   = 180;
    localparam int NUM_PHASES    = 9;
    // Phase that also carries the URLs around the length limit.
    localparam int LONG_PHASE    = 7;
    // Phase run with both sides at full rate.
    localparam int QUIET_PHASE   = 3;

    typedef struct {
        logic                accepted;
        t_reason             reason;
        logic [HASH_W-1:0]   hash;
        logic [BUCKET_W-1:0] bucket;
    } t_verdict;

    typedef struct {
        logic [BYTE_W-1:0] b;
        logic              last;
        bit                typed;
        t_verdict          v;
    } t_stim_row;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                cfg_we;
    logic [BUCKET_W-1:0] cfg_wdata;

    udhp_in_if  in_if ();
    udhp_out_if out_if ();

    url_domain_hash_partitioner_core i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in        (in_if),
        .o_out       (out_if),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Predictor state: one URL in flight plus the bucket count it is reduced by.
    t_phase              scan_phase;
    logic [HASH_W-1:0]   hash_acc;
    logic [3*BYTE_W-1:0] recent;
    logic                blog_seen;
    logic                query_seen;
    logic [BYTES_W-1:0]  url_len;
    logic [BUCKET_W-1:0] bucket_cfg;

    t_verdict  verdicts[$];      // verdicts still owed by the block, oldest first
    t_stim_row dir_rows[$];
    logic [BYTE_W-1:0] url_buf[$];

    bit       typed_next;        // current byte carries a hand-written verdict
    t_verdict typed_v;
    t_verdict pred_v;
    t_verdict got_v;
    bit       quiet;
    int       errors;
    int       sent;
    int       rdy_hold;

    function automatic void clear_url();
        scan_phase = PH_PRE;
        hash_acc   = '0;
        recent     = '0;
        blog_seen  = 1'b0;
        query_seen = 1'b0;
        url_len    = '0;
    endfunction

    // Advance the predictor by one byte; return 1 with the verdict on a last byte.
    function automatic bit advance_scan(input logic [BYTE_W-1:0] b, input logic last,
                                        output t_verdict v);
        logic [8:0]          mag;
        logic [HASH_W:0]     wide;
        t_reason             rsn;
        logic [BUCKET_W-1:0] div;
        v = '{accepted: 1'b0, reason: RSN_NONE, hash: '0, bucket: '0};
        if (url_len <= MAX_URL_BYTES)
            url_len++;
        if (b == CH_HASH || b == CH_QUERY)
            query_seen = 1'b1;
        // "blog" completes when 'g' follows "blo" in the three previous bytes
        if (b == CH_G && recent == STR_BLO)
            blog_seen = 1'b1;
        recent = {recent[2*BYTE_W-1:0], b};
        case (scan_phase)
            PH_PRE: begin
                if (b == CH_DOT)
                    scan_phase = PH_DOMAIN;
            end
            PH_DOMAIN: begin
                if (b == CH_SLASH) begin
                    scan_phase = PH_PATH;
                end else begin
                    // magnitude of the byte read as signed; 0x80 gives 128
                    mag  = b[7] ? (9'd256 - {1'b0, b}) : {1'b0, b};
                    wide = {1'b0, hash_acc} + mag;
                    hash_acc = (wide > HASH_MAX) ? HASH_MAX : wide[HASH_W-1:0];
                end
            end
            default: ;
        endcase
        if (!last)
            return 1'b0;
        // length beats "blog", which beats '#'/'?'
        rsn = (url_len > MAX_URL_BYTES) ? RSN_LONG :
              blog_seen                 ? RSN_BLOG :
              query_seen                ? RSN_QUERY : RSN_NONE;
        div = (bucket_cfg == '0) ? BUCKET_W'(1) : bucket_cfg;
        v.accepted = (rsn == RSN_NONE);
        v.reason   = rsn;
        v.hash     = hash_acc;
        v.bucket   = (rsn == RSN_NONE) ? BUCKET_W'(hash_acc % div) : '0;
        clear_url();
        return 1'b1;
    endfunction

    function automatic void check_field(input string what, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
            errors++;
        end
    endfunction

    // Gap before a transaction or length of a receiver stall: mostly short, a few long.
    function automatic int pick_gap();
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(11, 30);
    endfunction

    function automatic void add_row(input logic [BYTE_W-1:0] b, input int last,
                                    input int typed, input int acc, input t_reason rsn,
                                    input int hash);
        t_stim_row row;
        row.b     = b;
        row.last  = last[0];
        row.typed = typed[0];
        row.v     = '{accepted: acc[0], reason: rsn, hash: HASH_W'(hash), bucket: '0};
        dir_rows.push_back(row);
    endfunction

    function automatic void push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            url_buf.push_back(s[i]);
    endfunction

    function automatic logic [BYTE_W-1:0] text_byte();
        int r;
        r = $urandom_range(0, 99);
        if (r < 78) return BYTE_W'(8'h61 + $urandom_range(0, 25));
        if (r < 86) return BYTE_W'(8'h30 + $urandom_range(0, 9));
        if (r < 90) return 8'h2D;
        if (r < 93) return CH_DOT;
        return BYTE_W'($urandom_range(0, 255));
    endfunction

    // Build one random URL: mostly well formed, the rest noise and near misses.
    function automatic void build_url();
        string frags[12] = '{"b", "l", "o", "g", "blo", "blog", ".", "/", "#", "?",
                             "bl", "og"};
        int r;
        int n;
        int pos;
        url_buf.delete();
        r = $urandom_range(0, 99);
        if (r < 70) begin
            n = $urandom_range(0, 6);
            repeat (n) url_buf.push_back(BYTE_W'(8'h61 + $urandom_range(0, 25)));
            url_buf.push_back(CH_DOT);
            n = $urandom_range(1, 20);
            repeat (n) url_buf.push_back(text_byte());
            if ($urandom_range(0, 9) < 7) begin
                url_buf.push_back(CH_SLASH);
                n = $urandom_range(0, 15);
                repeat (n) url_buf.push_back(text_byte());
            end
            if ($urandom_range(0, 9) == 0) begin
                pos = $urandom_range(0, url_buf.size());
                url_buf.insert(pos, CH_G);
                url_buf.insert(pos, STR_BLO[7:0]);
                url_buf.insert(pos, STR_BLO[15:8]);
                url_buf.insert(pos, STR_BLO[23:16]);
            end
            if ($urandom_range(0, 99) < 8)
                url_buf.insert($urandom_range(0, url_buf.size()),
                               $urandom_range(0, 1) ? CH_HASH : CH_QUERY);
        end else if (r < 85) begin
            n = $urandom_range(1, 12);
            repeat (n) url_buf.push_back(BYTE_W'($urandom_range(0, 255)));
        end else if (r < 95) begin
            n = $urandom_range(1, 8);
            repeat (n) push_text(frags[$urandom_range(0, 11)]);
        end else begin
            // domain of bytes with the largest magnitude, or a bare dot
            url_buf.push_back(CH_DOT);
            n = $urandom_range(0, 40);
            repeat (n) url_buf.push_back($urandom_range(0, 1) ? 8'h80 : 8'h7F);
        end
    endfunction

    function automatic void build_long(input int len, input bit blog_head,
                                       input logic [BYTE_W-1:0] fill);
        url_buf.delete();
        if (blog_head)
            push_text("blog");
        push_text("a.");
        while (url_buf.size() < len)
            url_buf.push_back(fill);
    endfunction

    // Offer one byte after a random gap and hold it until the transaction completes.
    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic last);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_if.valid     <= 1'b1;
        in_if.url_byte  <= b;
        in_if.last_byte <= last;
        @(negedge clk);
        while (!in_if.ready) @(negedge clk);
        @(posedge clk);
        sent++;
    endtask

    task automatic send_url();
        for (int i = 0; i < url_buf.size(); i++)
            send_byte(url_buf[i], i == url_buf.size() - 1);
    endtask

    // Drop valid and wait for every owed verdict plus the back-stage latency.
    task automatic drain();
        in_if.valid <= 1'b0;
        while (verdicts.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_bucket_count(input logic [BUCKET_W-1:0] v);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        bucket_cfg = v;
    endtask

    // Input monitor: predict on every accepted byte transaction.
    always @(negedge clk) begin
        if (rst_n && in_if.valid && in_if.ready) begin
            if (advance_scan(in_if.url_byte, in_if.last_byte, pred_v))
                verdicts.push_back(typed_next ? typed_v : pred_v);
        end
    end

    // Output monitor: compare each verdict transaction with the oldest owed verdict.
    always @(negedge clk) begin
        if (rst_n && out_if.valid && out_if.ready) begin
            if (verdicts.size() == 0) begin
                $display("%0t: unexpected verdict, expected none, actual hash %0d", $time,
                         out_if.domain_hash);
                errors++;
            end else begin
                got_v = verdicts.pop_front();
                check_field("accepted", got_v.accepted, out_if.accepted);
                check_field("reject_reason", got_v.reason, out_if.reject_reason);
                check_field("domain_hash", got_v.hash, out_if.domain_hash);
                check_field("bucket", got_v.bucket, out_if.bucket);
            end
        end
    end

    // Receiver: alternate ready runs and stalls of random length.
    always @(posedge clk) begin
        if (quiet) begin
            out_if.ready <= 1'b1;
        end else if (rdy_hold > 0) begin
            rdy_hold--;
        end else if ($urandom_range(0, 2) != 0) begin
            out_if.ready <= 1'b1;
            rdy_hold = $urandom_range(0, 8);
        end else begin
            out_if.ready <= 1'b0;
            rdy_hold = pick_gap();
        end
    end

    initial begin
        #40_000_000;
        $display("status: fail");
        $finish;
    end

    initial begin
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_wdata       = '0;
        in_if.valid     = 1'b0;
        in_if.url_byte  = '0;
        in_if.last_byte = 1'b0;
        out_if.ready    = 1'b0;
        rdy_hold        = 0;
        quiet           = 1'b0;
        typed_next      = 1'b0;
        errors          = 0;
        sent            = 0;
        bucket_cfg      = BUCKET_W'(1);
        clear_url();

        // Directed table under the reset bucket count of 1, so every bucket is 0.
        add_row(8'h00, 1, 1, 1, RSN_NONE, 0);          // no dot: hash 0
        add_row(CH_DOT, 0, 0, 0, RSN_NONE, 0);         // byte extremes after the dot
        add_row(8'h80, 0, 0, 0, RSN_NONE, 0);
        add_row(8'h7F, 0, 0, 0, RSN_NONE, 0);
        add_row(8'hFF, 1, 1, 1, RSN_NONE, 256);
        add_row(CH_HASH, 1, 1, 0, RSN_QUERY, 0);       // lone '#'
        add_row(8'h62, 0, 0, 0, RSN_NONE, 0);          // "blog"
        add_row(8'h6C, 0, 0, 0, RSN_NONE, 0);
        add_row(8'h6F, 0, 0, 0, RSN_NONE, 0);
        add_row(CH_G, 1, 1, 0, RSN_BLOG, 0);
        add_row(CH_QUERY, 0, 0, 0, RSN_NONE, 0);       // "?blog": blog wins over '?'
        add_row(8'h62, 0, 0, 0, RSN_NONE, 0);
        add_row(8'h6C, 0, 0, 0, RSN_NONE, 0);
        add_row(8'h6F, 0, 0, 0, RSN_NONE, 0);
        add_row(CH_G, 1, 1, 0, RSN_BLOG, 0);
        add_row(CH_DOT, 0, 0, 0, RSN_NONE, 0);         // ".a/b": slash ends the domain
        add_row(8'h61, 0, 0, 0, RSN_NONE, 0);
        add_row(CH_SLASH, 0, 0, 0, RSN_NONE, 0);
        add_row(8'h62, 1, 1, 1, RSN_NONE, 97);
        add_row(8'h61, 0, 0, 0, RSN_NONE, 0);          // "a..": second dot is hashed
        add_row(CH_DOT, 0, 0, 0, RSN_NONE, 0);
        add_row(CH_DOT, 1, 1, 1, RSN_NONE, 46);
        add_row(8'h78, 0, 0, 0, RSN_NONE, 0);          // "x.?": rejected, hash kept
        add_row(CH_DOT, 0, 0, 0, RSN_NONE, 0);
        add_row(CH_QUERY, 1, 1, 0, RSN_QUERY, 63);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i]) begin
            typed_next = dir_rows[i].typed;
            typed_v    = dir_rows[i].v;
            send_byte(dir_rows[i].b, dir_rows[i].last);
        end
        typed_next = 1'b0;
        drain();

        for (int p = 0; p < NUM_PHASES; p++) begin
            quiet = (p == QUIET_PHASE);
            case (p)
                0:       write_bucket_count('0);
                1:       write_bucket_count('1);
                2:       write_bucket_count(BUCKET_W'(3));
                3:       write_bucket_count(BUCKET_W'(1));
                4:       write_bucket_count(BUCKET_W'($urandom_range(2, 400)));
                5:       write_bucket_count(BUCKET_W'($urandom_range(1, 65535)));
                6:       write_bucket_count(BUCKET_W'(2));
                7:       write_bucket_count('1);
                default: write_bucket_count(BUCKET_W'($urandom_range(1, 1000)));
            endcase
            if (p == LONG_PHASE) begin
                // exactly at the limit, one past it, and far past it with saturation
                build_long(MAX_URL_BYTES, 1'b0, 8'h80);
                send_url();
                build_long(MAX_URL_BYTES + 1, 1'b0, BYTE_W'($urandom_range(0, 255)));
                send_url();
                build_long(2 * MAX_URL_BYTES + 200, 1'b1, 8'h80);
                send_url();
            end
            sent = 0;
            while (sent < PHASE_BYTES) begin
                build_url();
                send_url();
            end
            drain();
        end

        if (errors == 0 && verdicts.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

### files.f
+incdir+design
design/udhp_pkg.sv
design/udhp_in_if.sv
design/udhp_out_if.sv
design/udhp_front.sv
design/udhp_queue.sv
design/udhp_back.sv
design/url_domain_hash_partitioner_core.sv
tb/tb_url_domain_hash_partitioner_core.sv
